### rtl/owa_pkg.sv
// ----------------------------------------------------------------------------
// owa_pkg: shared types and constants
// Field widths, band scale factors and sequencer states for the
// outlier-rejecting window average.
// ----------------------------------------------------------------------------
package owa_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int COUNT_W    = 4;
  localparam int COUNT_MAX  = 15;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  // band limits are compared as 100*v against mean*95 and mean*105
  localparam int PROD_W   = 17;
  localparam int LOW_PCT  = 95;
  localparam int HIGH_PCT = 105;
  localparam int SCALE    = 100;

  // window mean as (total * ceil(2^MEAN_SHIFT / WINDOW)) >> MEAN_SHIFT,
  // exact for every window total up to 16 full-scale samples
  localparam int MEAN_SHIFT = 18;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_MEAN,
    S_BOUND,
    S_FILT,
    S_KSTART,
    S_KWAIT,
    S_DONE
  } owa_state_t;

endpackage

### rtl/owa_cell.sv
// ----------------------------------------------------------------------------
// owa_cell: one window sample cell
// Holds one sample, cleared at reset, and takes its neighbor's sample on
// every shift.
// ----------------------------------------------------------------------------
module owa_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift_en,
  input  logic [owa_pkg::SAMPLE_W-1:0]  d_in,
  output logic [owa_pkg::SAMPLE_W-1:0]  q
);
  import owa_pkg::*;

  logic [SAMPLE_W-1:0] val_r;
  logic [SAMPLE_W-1:0] val_nxt;

  always_comb begin
    val_nxt = shift_en ? d_in : val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign q = val_r;

endmodule

### rtl/owa_div.sv
// ----------------------------------------------------------------------------
// owa_div: radix-2 restoring divider
// Unsigned divide, one quotient bit per cycle; done pulses with the
// quotient ready.
// ----------------------------------------------------------------------------
module owa_div #(
  parameter int DIVIDEND_W = 14,
  parameter int DIVISOR_W  = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);
  localparam int STEP_W = $clog2(DIVIDEND_W);

  logic                  busy_r;
  logic                  done_r;
  logic [STEP_W-1:0]     cnt_r;
  logic [DIVISOR_W-1:0]  div_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [DIVIDEND_W-1:0] quo_r;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;
  logic [DIVISOR_W-1:0]  rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[DIVIDEND_W-1]};
    diff    = trial - {1'b0, div_r};
    fits    = trial >= {1'b0, div_r};
    rem_nxt = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= STEP_W'(DIVIDEND_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIVIDEND_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/outlier_rejecting_window_average_unit.sv
// ----------------------------------------------------------------------------
// outlier_rejecting_window_average_unit: window mean with +/-5% outlier drop
// Keeps the last WINDOW light samples and reports the window mean, the
// number of samples within 95%..105% of it and the mean of those samples.
// ----------------------------------------------------------------------------
// One word in gives one word out. The samples sit in a chain of cells that
// is rotated once to sum the window and once to test each sample against
// the band, the window mean comes from one reciprocal multiply, and a
// radix-2 divider forms the kept mean one bit per cycle. When no sample is
// in band the division is skipped and the previous level is repeated. A
// stalled output word holds the unit in S_DONE until it is taken. in_tready
// is high between items; a finished word waits in the output register while
// the next item is taken.
module outlier_rejecting_window_average_unit #(
  parameter int WINDOW = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [9:0] light_sample, [15:10] zero
  input  logic [owa_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [9:0] filtered_level, [13:10] kept_count, [23:14] window_mean
  output logic [owa_pkg::OUT_DATA_W-1:0] out_tdata
);
  import owa_pkg::*;

  localparam int SUM_W = $clog2(WINDOW * (2**SAMPLE_W - 1) + 1);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int IDX_W = $clog2(WINDOW);
  localparam int KX_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int MUL_W = SUM_W + MEAN_SHIFT;
  localparam int MEAN_RECIP = (2**MEAN_SHIFT + WINDOW - 1) / WINDOW;

  owa_state_t state_r, state_nxt;

  logic [SAMPLE_W-1:0]   tap [WINDOW];
  logic [SAMPLE_W-1:0]   head_in;
  logic [SAMPLE_W-1:0]   tail;
  logic                  shift_en;
  logic                  in_acc;

  logic [IDX_W-1:0]      rot_cnt_r;
  logic                  rot_last;

  logic [SUM_W-1:0]      total_r;
  logic [SUM_W-1:0]      kept_sum_r;
  logic [CNT_W-1:0]      kept_r;
  logic [SAMPLE_W-1:0]   mean_r;
  logic [SAMPLE_W-1:0]   held_r;
  logic [PROD_W-1:0]     low_r;
  logic [PROD_W-1:0]     high_r;
  logic [PROD_W-1:0]     scaled;
  logic                  in_band;
  logic [MUL_W-1:0]      mean_prod;

  logic                  div_start;
  logic [SUM_W-1:0]      div_dividend;
  logic [CNT_W-1:0]      div_divisor;
  logic                  div_done;
  logic [SUM_W-1:0]      div_quotient;

  logic [KX_W-1:0]       kept_x;
  logic [COUNT_W-1:0]    kept_field;
  logic                  out_load;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  // sample chain
  assign head_in  = (state_r == S_IDLE) ? in_tdata[SAMPLE_W-1:0] : tail;
  assign tail     = tap[WINDOW-1];
  assign shift_en = in_acc || (state_r == S_SUM) || (state_r == S_FILT);

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      owa_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d_in     (head_in),
        .q        (tap[i])
      );
    end else begin : g_body
      owa_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .d_in     (tap[i-1]),
        .q        (tap[i])
      );
    end
  end

  owa_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_tvalid) state_nxt = S_SUM;
      S_SUM:    if (rot_last) state_nxt = S_MEAN;
      S_MEAN:   state_nxt = S_BOUND;
      S_BOUND:  state_nxt = S_FILT;
      S_FILT:   if (rot_last) state_nxt = S_KSTART;
      S_KSTART: state_nxt = (kept_r != '0) ? S_KWAIT : S_DONE;
      S_KWAIT:  if (div_done) state_nxt = S_DONE;
      S_DONE:   if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready    = (state_r == S_IDLE);
    in_acc       = in_tready && in_tvalid;
    rot_last     = (rot_cnt_r == IDX_W'(WINDOW - 1));
    div_start    = 1'b0;
    div_dividend = kept_sum_r;
    div_divisor  = kept_r;
    out_load     = 1'b0;
    unique case (state_r)
      S_KSTART: div_start = (kept_r != '0);
      S_DONE:   out_load = !out_valid_r || out_tready;
      default:  div_start = 1'b0;
    endcase
  end

  always_comb begin
    mean_prod = MUL_W'(total_r) * MUL_W'(MEAN_RECIP);
    scaled  = PROD_W'(tail) * PROD_W'(SCALE);
    in_band = (low_r <= scaled + PROD_W'(SCALE - 1)) && (scaled <= high_r);
    kept_x  = KX_W'(kept_r);
    kept_field = (kept_x > KX_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX) : kept_x[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rot_cnt_r   <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_SUM) || (state_r == S_FILT)) begin
        rot_cnt_r <= rot_last ? '0 : rot_cnt_r + 1'b1;
      end
      if ((state_r == S_KWAIT) && div_done) begin
        held_r <= div_quotient[SAMPLE_W-1:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      total_r    <= '0;
      kept_sum_r <= '0;
      kept_r     <= '0;
    end
    if (state_r == S_SUM) begin
      total_r <= total_r + SUM_W'(tail);
    end
    if (state_r == S_MEAN) begin
      mean_r <= mean_prod[MEAN_SHIFT +: SAMPLE_W];
    end
    if (state_r == S_BOUND) begin
      low_r  <= PROD_W'(mean_r) * PROD_W'(LOW_PCT);
      high_r <= PROD_W'(mean_r) * PROD_W'(HIGH_PCT);
    end
    if ((state_r == S_FILT) && in_band) begin
      kept_sum_r <= kept_sum_r + SUM_W'(tail);
      kept_r     <= kept_r + 1'b1;
    end
    if (out_load) begin
      out_data_r <= {mean_r, kept_field, held_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### rtl/owa_checker.sv
// ----------------------------------------------------------------------------
// owa_checker: port-level checks for the window average unit
// Watches the stream ports and the hold-on-empty-band behavior.
// ----------------------------------------------------------------------------
module owa_checker #(
  parameter int WINDOW = 10
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [owa_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [owa_pkg::OUT_DATA_W-1:0] out_tdata
);
  import owa_pkg::*;

  logic [SAMPLE_W-1:0] last_level_r;
  logic [COUNT_W-1:0]  kept_field;
  logic [SAMPLE_W-1:0] level_field;
  logic                unused_in;

  assign level_field = out_tdata[SAMPLE_W-1:0];
  assign kept_field  = out_tdata[SAMPLE_W+COUNT_W-1:SAMPLE_W];
  assign unused_in   = ^in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= '0;
    end else if (out_tvalid && out_tready) begin
      last_level_r <= level_field;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in progress");

  a_kept_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(kept_field) <= 32'(WINDOW)) || (unused_in && !unused_in))
    else $error("kept count exceeds window");

  a_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (kept_field == '0) |-> level_field == last_level_r)
    else $error("level not held when no sample is in band");

endmodule

bind outlier_rejecting_window_average_unit owa_checker #(.WINDOW(WINDOW)) u_owa_checker (.*);

### tb/window_average_checker.sv
// ----------------------------------------------------------------------------
// window_average_checker: prediction and comparison for the window average
// Watches both stream channels of the outlier-rejecting window average. Each
// accepted sample word updates a private copy of the sample window and pushes
// the predicted level word; each accepted output word is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module window_average_checker #(
  parameter int WINDOW = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  // [9:0] light_sample, [15:10] zero
  input  logic [owa_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  // [9:0] filtered_level, [13:10] kept_count, [23:14] window_mean
  input  logic [owa_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             mismatch_count,
  output int                             levels_due
);
  import owa_pkg::*;

  typedef struct packed {
    logic [SAMPLE_W-1:0] window_mean;
    logic [COUNT_W-1:0]  kept_count;
    logic [SAMPLE_W-1:0] filtered_level;
  } level_word_t;

  logic [SAMPLE_W-1:0] sample_window [WINDOW];
  int unsigned         newest_slot;
  logic [SAMPLE_W-1:0] held_level;
  level_word_t         predicted_levels [$];

  function automatic level_word_t compute_level(logic [SAMPLE_W-1:0] sample);
    int unsigned total;
    int unsigned mean;
    int unsigned lo_bound;
    int unsigned hi_bound;
    int unsigned kept;
    int unsigned kept_sum;
    level_word_t w;
    newest_slot = (newest_slot >= WINDOW - 1) ? 0 : newest_slot + 1;
    sample_window[newest_slot] = sample;
    total = 0;
    foreach (sample_window[i]) total += sample_window[i];
    mean = total / WINDOW;
    lo_bound = (mean * LOW_PCT) / SCALE;
    hi_bound = (mean * HIGH_PCT) / SCALE;
    kept = 0;
    kept_sum = 0;
    foreach (sample_window[i]) begin
      if (sample_window[i] >= lo_bound && sample_window[i] <= hi_bound) begin
        kept_sum += sample_window[i];
        kept++;
      end
    end
    if (kept > 0) held_level = SAMPLE_W'(kept_sum / kept);
    w.filtered_level = held_level;
    w.kept_count = (kept > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(kept);
    w.window_mean = SAMPLE_W'(mean);
    return w;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    level_word_t seen;
    level_word_t want;
    if (!rst_n) begin
      foreach (sample_window[i]) sample_window[i] = '0;
      newest_slot = WINDOW - 1;
      held_level = '0;
      predicted_levels.delete();
      mismatch_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen = out_tdata;
        if (predicted_levels.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %h", $time, seen);
          mismatch_count++;
        end else begin
          want = predicted_levels.pop_front();
          check_field("filtered_level", want.filtered_level, seen.filtered_level);
          check_field("kept_count", want.kept_count, seen.kept_count);
          check_field("window_mean", want.window_mean, seen.window_mean);
        end
      end
      if (in_tvalid && in_tready)
        predicted_levels.push_back(compute_level(in_tdata[SAMPLE_W-1:0]));
    end
    levels_due = predicted_levels.size();
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the outlier-rejecting window average
// Drives directed sample words (extremes, empty band, upper bound above full
// scale, set pad bits) and then clustered random samples with outliers,
// with random idle bursts on both channels. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import owa_pkg::*;

  localparam int WINDOW      = 10;
  localparam int RANDOM_WORDS = 1330;
  localparam int CALM_FROM    = 1180;
  localparam int CYCLE_LIMIT  = 600000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    mismatch_count;
  int                    levels_due;
  int                    cycle_count = 0;
  bit                    calm;

  logic [IN_DATA_W-1:0] directed_words [$] = '{
    16'd1023, 16'd0,
    16'd1023, 16'd1023, 16'd1023, 16'd1023, 16'd1023,
    16'd1023, 16'd1023, 16'd1023, 16'd1023, 16'd1023,
    16'hFC00 | 16'd300, 16'h0400 | 16'd300,
    16'd0, 16'd1, 16'd512, 16'd511, 16'd2, 16'd1022
  };

  outlier_rejecting_window_average_unit #(.WINDOW(WINDOW)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  window_average_checker #(.WINDOW(WINDOW)) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .levels_due     (levels_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (!calm && (cycle_count % 1500) >= 300 && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [IN_DATA_W-1:0] word, input bit allow_gap);
    int gap;
    gap = 0;
    if (allow_gap && !calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_levels();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (levels_due != 0) @(negedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(int base);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      v = $urandom_range(0, base / 12 + 1);
      v = $urandom_range(0, 1) ? base + v : base - v;
    end else if (r < 65) begin
      v = $urandom_range(0, 1) ? (base * HIGH_PCT) / SCALE : (base * LOW_PCT) / SCALE;
    end else if (r < 80) begin
      v = $urandom_range(0, 1023);
    end else if (r < 90) begin
      v = $urandom_range(0, 1) ? 1023 : 0;
    end else begin
      v = base;
    end
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return SAMPLE_W'(v);
  endfunction

  initial begin
    int n;
    int base;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    calm        = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_words[i]) send_word(directed_words[i], 1'b1);
    drain_levels();

    base = $urandom_range(0, 1023);
    for (n = 0; n < RANDOM_WORDS; n++) begin
      if ($urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 4))
          0:       base = $urandom_range(0, 20);
          1:       base = $urandom_range(975, 1023);
          default: base = $urandom_range(0, 1023);
        endcase
      end
      calm = (n >= CALM_FROM);
      if (n == RANDOM_WORDS / 2) drain_levels();
      send_word({{(IN_DATA_W - SAMPLE_W){1'b0}}, pick_sample(base)}, (n / 64) % 3 != 2);
    end
    drain_levels();
    repeat (100) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
rtl/owa_pkg.sv
rtl/owa_cell.sv
rtl/owa_div.sv
rtl/outlier_rejecting_window_average_unit.sv
rtl/owa_checker.sv
tb/window_average_checker.sv
tb/testbench.sv
